// ===== design/cdts_pkg.sv =====
// Package for the counter-decay task scheduler: sizes, codes, table entry
// layout and the structs that pass between the controller, memory and top.
// No dependencies.
`default_nettype none

package cdts_pkg;

    // Table size and recompute bound
    localparam int MAX_TASKS     = 64;
    localparam int MAX_RECOMPUTE = 16;

    // Derived widths
    localparam int IDX_W   = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int PASS_W  = $clog2(MAX_RECOMPUTE + 1);

    // Fixed field widths
    localparam int SLOT_W  = 6;
    localparam int CTR_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int DEPTH_W = 8;
    localparam int MASK_W  = 64;

    typedef logic signed [CTR_W-1:0] cdts_ctr_t;

    localparam cdts_ctr_t CTR_MIN = {1'b1, {(CTR_W-1){1'b0}}};
    localparam cdts_ctr_t CTR_MAX = {1'b0, {(CTR_W-1){1'b1}}};

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [PRIO_W-1:0]  prio;
        cdts_ctr_t          counter;
    } cdts_entry_t;

    // Slot 0 content right after reset
    localparam cdts_entry_t ENTRY_RESET0 = '{
        depth:   '0,
        prio:    PRIO_W'(1),
        counter: '0
    };

    typedef enum logic [2:0] {
        REQ_TICK        = 3'd0,
        REQ_YIELD       = 3'd1,
        REQ_EXIT        = 3'd2,
        REQ_REAP        = 3'd3,
        REQ_PREEMPT_OFF = 3'd4,
        REQ_PREEMPT_ON  = 3'd5,
        REQ_CREATE      = 3'd6
    } cdts_req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BOUND    = 2'd1,
        ST_OCCUPIED = 2'd2
    } cdts_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR_MOD,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } cdts_state_t;

    // Memory read and write requests
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } cdts_mem_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        cdts_entry_t      data;
    } cdts_mem_wr_t;

    // Result of one event
    typedef struct packed {
        logic [SLOT_W-1:0] current_task;
        logic              switched;
        logic [MASK_W-1:0] reaped_mask;
        cdts_status_t      status;
    } cdts_result_t;

endpackage

`default_nettype wire

// ===== design/cdts_req_if.sv =====
// Request channel of the scheduler: valid/ready plus the event fields.
// Depends on cdts_pkg.
`default_nettype none

interface cdts_req_if import cdts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, output req_type, output slot, output priority_req,
                    input ready);
    modport sink   (input valid, input req_type, input slot, input priority_req,
                    output ready);
endinterface

`default_nettype wire

// ===== design/cdts_rsp_if.sv =====
// Response channel of the scheduler: valid/ready plus the result fields.
// Depends on cdts_pkg.
`default_nettype none

interface cdts_rsp_if import cdts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] current_task;
    logic              switched;
    logic [MASK_W-1:0] reaped_mask;
    logic [1:0]        status;

    modport source (output valid, output current_task, output switched,
                    output reaped_mask, output status, input ready);
    modport sink   (input valid, input current_task, input switched,
                    input reaped_mask, input status, output ready);
endinterface

`default_nettype wire

// ===== design/cdts_mem.sv =====
// Slot memory: one entry per task slot (counter, priority, preempt depth).
// One write and one read port, registered read data. Depends on cdts_pkg.
`default_nettype none

module cdts_mem import cdts_pkg::*;
(
    input  wire logic         clk,
    input  wire cdts_mem_rd_t rd,
    input  wire cdts_mem_wr_t wr,
    output cdts_entry_t       rd_data
);

    cdts_entry_t mem_array [MAX_TASKS];
    cdts_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem_array[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/cdts_ctrl.sv =====
// Scheduler controller: event decode, read-modify-write of the current slot,
// scan/recompute passes over the slot memory, valid/zombie flags.
// Depends on cdts_pkg, cdts_req_if.
`default_nettype none

module cdts_ctrl import cdts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    cdts_req_if.sink         req,
    input  wire logic        rsp_free,
    output logic             res_valid,
    output cdts_result_t     res,
    output cdts_mem_rd_t     rd,
    output cdts_mem_wr_t     wr,
    input  wire cdts_entry_t rd_data
);

    localparam cdts_ctr_t CTR_ONE = CTR_W'(1);

    cdts_state_t               state_reg, state_next;
    logic [IDX_W-1:0]          running_reg, running_next;
    logic [MAX_TASKS-1:0]      valid_reg, valid_next;
    logic [MAX_TASKS-1:0]      zombie_reg, zombie_next;
    logic                      fresh0_reg, fresh0_next;
    cdts_req_t                 req_reg, req_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      rvld_reg;
    logic [IDX_W-1:0]          raddr_reg;
    cdts_ctr_t                 best_reg, best_next;
    logic [IDX_W-1:0]          sel_reg, sel_next;
    logic [PASS_W-1:0]         pass_reg, pass_next;
    logic                      recomp_reg, recomp_next;
    cdts_status_t              st_reg, st_next;
    logic [MASK_W-1:0]         reaped_reg, reaped_next;
    logic                      switched_reg, switched_next;

    cdts_req_t                 req_in;
    logic                      accept;
    cdts_entry_t               rdata_eff;
    logic                      cv;
    cdts_ctr_t                 dec;
    logic                      dec_pos;
    logic signed [CTR_W:0]     recomp_sum;
    cdts_ctr_t                 recomp_val;
    cdts_ctr_t                 scan_val;
    logic                      scan_live;
    logic [MAX_TASKS-1:0]      reap_bits;
    logic [IDX_W-1:0]          slot_idx;

    assign req_in    = cdts_req_t'(req.req_type);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_idx  = req.slot[IDX_W-1:0];
    assign reap_bits = valid_reg & zombie_reg;

    // Slot 0 reads its reset content until it is first written
    assign rdata_eff = (fresh0_reg && raddr_reg == '0) ? ENTRY_RESET0 : rd_data;

    // Current-slot arithmetic
    assign cv      = valid_reg[running_reg];
    assign dec     = (rdata_eff.counter == CTR_MIN) ? CTR_MIN : rdata_eff.counter - CTR_ONE;
    assign dec_pos = !dec[CTR_W-1] && (dec != '0);

    // Recompute: floor(counter/2) + priority, saturating
    assign recomp_sum = {{2{rdata_eff.counter[CTR_W-1]}}, rdata_eff.counter[CTR_W-1:1]}
                      + $signed({{(CTR_W+1-PRIO_W){1'b0}}, rdata_eff.prio});
    assign recomp_val = (recomp_sum[CTR_W] != recomp_sum[CTR_W-1]) ? CTR_MAX
                      : recomp_sum[CTR_W-1:0];
    assign scan_val   = (recomp_reg && valid_reg[raddr_reg]) ? recomp_val : rdata_eff.counter;
    assign scan_live  = valid_reg[raddr_reg] && !zombie_reg[raddr_reg];

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            running_reg  <= '0;
            valid_reg    <= MAX_TASKS'(1);
            zombie_reg   <= '0;
            fresh0_reg   <= 1'b1;
            rvld_reg     <= 1'b0;
            idx_reg      <= '0;
            pass_reg     <= '0;
            recomp_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            valid_reg    <= valid_next;
            zombie_reg   <= zombie_next;
            fresh0_reg   <= fresh0_next;
            rvld_reg     <= rd.en;
            idx_reg      <= idx_next;
            pass_reg     <= pass_next;
            recomp_reg   <= recomp_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        best_reg     <= best_next;
        sel_reg      <= sel_next;
        st_reg       <= st_next;
        reaped_reg   <= reaped_next;
        switched_reg <= switched_next;
        if (rd.en)
        begin
            raddr_reg <= rd.addr;
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        running_next  = running_reg;
        valid_next    = valid_reg;
        zombie_next   = zombie_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        sel_next      = sel_reg;
        pass_next     = pass_reg;
        recomp_next   = recomp_reg;
        st_next       = st_reg;
        reaped_next   = reaped_reg;
        switched_next = switched_reg;
        rd            = '0;
        wr            = '0;
        res_valid     = 1'b0;
        res           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = req_in;
                    st_next       = ST_OK;
                    reaped_next   = '0;
                    switched_next = 1'b0;
                    state_next    = S_DONE;
                    case (req_in)
                        REQ_TICK, REQ_YIELD, REQ_EXIT, REQ_PREEMPT_OFF, REQ_PREEMPT_ON:
                        begin
                            rd.en      = 1'b1;
                            rd.addr    = running_reg;
                            state_next = S_CUR_MOD;
                        end
                        REQ_REAP:
                        begin
                            valid_next  = valid_reg & ~reap_bits;
                            zombie_next = zombie_reg & ~reap_bits;
                            reaped_next = MASK_W'(reap_bits);
                        end
                        REQ_CREATE:
                        begin
                            if ({1'b0, req.slot} < (SLOT_W+1)'(MAX_TASKS))
                            begin
                                if (valid_reg[slot_idx])
                                begin
                                    st_next = ST_OCCUPIED;
                                end
                                else
                                begin
                                    valid_next[slot_idx]  = 1'b1;
                                    zombie_next[slot_idx] = 1'b0;
                                    wr.en                 = 1'b1;
                                    wr.addr               = slot_idx;
                                    wr.data.depth         = '0;
                                    wr.data.prio          = req.priority_req;
                                    wr.data.counter       = CTR_W'(req.priority_req);
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Current slot data is back: modify, write, maybe reschedule
            S_CUR_MOD:
            begin
                wr.addr    = running_reg;
                wr.data    = rdata_eff;
                state_next = S_DONE;
                case (req_reg)
                    REQ_TICK:
                    begin
                        if (cv)
                        begin
                            wr.en = 1'b1;
                            if (dec_pos || rdata_eff.depth != '0)
                            begin
                                wr.data.counter = dec;
                            end
                            else
                            begin
                                wr.data.counter = '0;
                                state_next      = S_SCAN;
                            end
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    REQ_YIELD:
                    begin
                        wr.en           = cv;
                        wr.data.counter = '0;
                        state_next      = S_SCAN;
                    end
                    REQ_EXIT:
                    begin
                        wr.en           = cv;
                        wr.data.counter = '0;
                        if (cv)
                        begin
                            zombie_next[running_reg] = 1'b1;
                        end
                        state_next = S_SCAN;
                    end
                    REQ_PREEMPT_OFF:
                    begin
                        wr.en         = cv && (rdata_eff.depth != '1);
                        wr.data.depth = rdata_eff.depth + DEPTH_W'(1);
                    end
                    REQ_PREEMPT_ON:
                    begin
                        wr.en         = cv && (rdata_eff.depth != '0);
                        wr.data.depth = rdata_eff.depth - DEPTH_W'(1);
                    end
                    default:
                    begin
                        wr.en = 1'b0;
                    end
                endcase
                // First scan pass, no recompute
                idx_next    = '0;
                best_next   = '1;
                sel_next    = '0;
                pass_next   = '0;
                recomp_next = 1'b0;
            end

            // Stream every slot through; recompute on later passes
            S_SCAN:
            begin
                if (idx_reg < CNT_W'(MAX_TASKS))
                begin
                    rd.en    = 1'b1;
                    rd.addr  = idx_reg[IDX_W-1:0];
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (rvld_reg)
                begin
                    if (recomp_reg && valid_reg[raddr_reg])
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = raddr_reg;
                        wr.data         = rdata_eff;
                        wr.data.counter = recomp_val;
                    end
                    if (scan_live && scan_val > best_reg)
                    begin
                        best_next = scan_val;
                        sel_next  = raddr_reg;
                    end
                    if (raddr_reg == IDX_W'(MAX_TASKS - 1))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            // Best counter zero: another recompute pass, or give up; else run the best slot
            S_DECIDE:
            begin
                if (best_reg == '0 && pass_reg < PASS_W'(MAX_RECOMPUTE))
                begin
                    pass_next   = pass_reg + PASS_W'(1);
                    recomp_next = 1'b1;
                    idx_next    = '0;
                    best_next   = '1;
                    sel_next    = '0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    if (best_reg == '0)
                    begin
                        st_next = ST_BOUND;
                    end
                    running_next  = sel_reg;
                    switched_next = (sel_reg != running_reg);
                    state_next    = S_DONE;
                end
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (rsp_free)
                begin
                    res_valid          = 1'b1;
                    res.current_task   = SLOT_W'(running_reg);
                    res.switched       = switched_reg;
                    res.reaped_mask    = reaped_reg;
                    res.status         = st_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fresh0_next = fresh0_reg && !(wr.en && wr.addr == '0);
    end

endmodule

`default_nettype wire

// ===== design/counter_decay_task_scheduler_unit.sv =====
// Counter-decay task scheduler, top level. Reap, create and unused codes go
// straight to the result; preempt on/off read, modify-write, then report. A
// reschedule (yield, exit, a tick that runs out) makes 1 to 17 passes over the
// slot memory, one entry read per cycle, before the result is reported.
// One event in flight; the next is accepted while a result waits.
// Reset: slot 0 valid with priority 1, all else clear; takes effect at once.
`default_nettype none

module counter_decay_task_scheduler_unit import cdts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cdts_req_if.sink  req,
    cdts_rsp_if.source rsp
);

    cdts_mem_rd_t rd;
    cdts_mem_wr_t wr;
    cdts_entry_t  rd_data;
    logic         res_valid;
    cdts_result_t res;
    logic         rsp_free;

    logic         rsp_valid_reg, rsp_valid_next;
    cdts_result_t rsp_data_reg;

    cdts_ctrl u_cdts_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_free  (rsp_free),
        .res_valid (res_valid),
        .res       (res),
        .rd        (rd),
        .wr        (wr),
        .rd_data   (rd_data)
    );

    cdts_mem u_cdts_mem (
        .clk     (clk),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    // Output register: free when empty or being taken this cycle
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.current_task = rsp_data_reg.current_task;
    assign rsp.switched     = rsp_data_reg.switched;
    assign rsp.reaped_mask  = rsp_data_reg.reaped_mask;
    assign rsp.status       = rsp_data_reg.status;

endmodule

`default_nettype wire

// ===== design/cdts_checker.sv =====
// Port-level checks for the scheduler top, attached by bind.
// Depends on cdts_pkg and counter_decay_task_scheduler_unit.
`default_nettype none

module cdts_checker import cdts_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [SLOT_W-1:0] rsp_current_task,
    input wire logic              rsp_switched,
    input wire logic [MASK_W-1:0] rsp_reaped_mask,
    input wire logic [1:0]        rsp_status
);

    // One event at a time: a taken beat drops ready on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request ready stayed high after an accepted beat");

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_task)
                                 && $stable(rsp_status))
        else $error("stalled result beat changed");

    // Reap never reschedules and never reports an error
    a_reap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_reaped_mask != '0 |-> !rsp_switched && rsp_status == ST_OK)
        else $error("reap result with switch or error status");

    // Create on an occupied slot changes nothing visible
    a_occupied_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_OCCUPIED |-> !rsp_switched && rsp_reaped_mask == '0)
        else $error("occupied-slot create reported a switch or reap");

endmodule

bind counter_decay_task_scheduler_unit cdts_checker u_cdts_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_current_task (rsp.current_task),
    .rsp_switched     (rsp.switched),
    .rsp_reaped_mask  (rsp.reaped_mask),
    .rsp_status       (rsp.status)
);

`default_nettype wire
